// ===== sv/s2x_pkg.sv =====
// shared types and constants of the scale2x pixel upscaler
// no dependencies; imported by the front, back and top level
package s2x_pkg;

    localparam int PIX_W     = 32;
    localparam int POS_W     = 9;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_BLK   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd240;

    // one classified source pixel, handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] prev1;
        logic [PIX_W-1:0] prev2;
        logic             endc;
        logic             lastrow;
        logic             refill;
        logic             nsel;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
    } t_block;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        t_block           pix;
    } t_result;

endpackage

// ===== sv/s2x_front.sv =====
// front part: config registers, raster counters and pixel classification
// depends on s2x_pkg; pushes one command word per accepted pixel
module s2x_front import s2x_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output logic [ROW_W-1:0]     o_row,
    output logic [COL_W-1:0]     o_col
);

    localparam int WX_W = CFG_W + COL_W + 1;
    localparam int HX_W = CFG_W + ROW_W + 1;

    logic [CFG_W-1:0] r_width, r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_nsel;
    logic [PIX_W-1:0] r_prev1, r_prev2;

    logic [WX_W-1:0]  w_ext, wl_ext;
    logic [HX_W-1:0]  h_ext, hl_ext;
    logic [COL_W-1:0] wl, c;
    logic [ROW_W-1:0] hl, r;
    logic             endc, lastrow, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FRAME_WIDTH_RST;
            r_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last usable column and row, zero acts as one, oversize saturates
    always_comb begin
        w_ext = WX_W'(r_width);
        h_ext = HX_W'(r_height);
        if (w_ext == '0) begin
            wl_ext = '0;
        end else if (w_ext > WX_W'(MAX_WIDTH)) begin
            wl_ext = WX_W'(MAX_WIDTH - 1);
        end else begin
            wl_ext = w_ext - WX_W'(1);
        end
        if (h_ext == '0) begin
            hl_ext = '0;
        end else if (h_ext > HX_W'(MAX_HEIGHT)) begin
            hl_ext = HX_W'(MAX_HEIGHT - 1);
        end else begin
            hl_ext = h_ext - HX_W'(1);
        end
        wl = wl_ext[COL_W-1:0];
        hl = hl_ext[ROW_W-1:0];
    end

    assign c       = (r_col > wl) ? wl : r_col;
    assign r       = (r_row > hl) ? hl : r_row;
    assign endc    = (c == wl);
    assign lastrow = (r == hl);

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        o_cmd.pix     = i_pixel;
        o_cmd.prev1   = r_prev1;
        o_cmd.prev2   = r_prev2;
        o_cmd.endc    = endc;
        o_cmd.lastrow = lastrow;
        // counter was cut back by a smaller width: back must reload its window
        o_cmd.refill  = (r_col > wl) && (c != '0);
        o_cmd.nsel    = r_nsel;
        o_row         = r;
        o_col         = c;
    end

    always_comb begin
        if (endc) begin
            n_col = '0;
            n_row = lastrow ? '0 : r + ROW_W'(1);
        end else begin
            n_col = c + COL_W'(1);
            n_row = r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_nsel  <= 1'b0;
            r_prev1 <= '0;
            r_prev2 <= '0;
        end else if (accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_nsel  <= r_nsel ^ endc;
            r_prev1 <= i_pixel;
            r_prev2 <= r_prev1;
        end
    end

endmodule

// ===== sv/s2x_queue.sv =====
// two-entry command queue between front and back
// depends on s2x_pkg only through the width its user passes in
module s2x_queue import s2x_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr, r_rd;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/s2x_back.sv =====
// back part: line stores, neighbour window, scale2x rule and result buffer
// depends on s2x_pkg; takes commands from the queue, drives the result channel
module s2x_back import s2x_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_cmd             i_cmd,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [POS_W-1:0] o_out_row,
    output logic [POS_W-1:0] o_out_col,
    output logic [PIX_W-1:0] o_top_left,
    output logic [PIX_W-1:0] o_top_right,
    output logic [PIX_W-1:0] o_bottom_left,
    output logic [PIX_W-1:0] o_bottom_right,
    output logic             o_last
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RF2  = 5'b00010,
        ST_RF1  = 5'b00100,
        ST_RD   = 5'b01000,
        ST_EX   = 5'b10000
    } t_state;

    function automatic t_block scale2x(input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] b,
                                       input logic [PIX_W-1:0] h, input logic [PIX_W-1:0] d,
                                       input logic [PIX_W-1:0] f);
        t_block blk;
        if (b != h && d != f) begin
            blk.tl = (d == b) ? d : e;
            blk.tr = (b == f) ? f : e;
            blk.bl = (d == h) ? d : e;
            blk.br = (h == f) ? f : e;
        end else begin
            blk.tl = e;
            blk.tr = e;
            blk.bl = e;
            blk.br = e;
        end
        return blk;
    endfunction

    function automatic logic [POS_W-1:0] pos9(input logic [31:0] v);
        return v[POS_W-1:0];
    endfunction

    t_state r_state, n_state;
    t_cmd             r_cmd;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    logic [PIX_W-1:0] r_bank0 [MAX_WIDTH];
    logic [PIX_W-1:0] r_bank1 [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd0, r_rd1;
    logic [PIX_W-1:0] r_n1, r_n2, r_o1;

    t_result    r_slot [NUM_BLK];
    t_result    n_slot [NUM_BLK];
    logic [2:0] r_idx, r_cnt, n_cnt;

    logic             can_load, load, pop, rd_en, wr_en;
    logic [COL_W-1:0] rd_addr, wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic [PIX_W-1:0] n0, o0;
    logic             r_ge1, r_ge2, c_ge1, c_ge2;
    logic [POS_W-1:0] row_up, row_at, col_left, col_at;
    t_result          blk [NUM_BLK];
    logic [NUM_BLK-1:0] blk_v;

    // buffer may be refilled when it is empty or drains this cycle
    assign can_load = (r_idx == r_cnt) || ((r_idx + 3'd1 == r_cnt) && i_out_ready);
    assign load     = (r_state == ST_EX) && can_load;
    assign pop      = i_q_valid && ((r_state == ST_IDLE) || load);
    assign o_q_pop  = pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    n_state = i_cmd.refill ? ST_RF2 : ST_RD;
                end
            end
            ST_RF2: n_state = ST_RF1;
            ST_RF1: n_state = ST_RD;
            ST_RD:  n_state = ST_EX;
            ST_EX: begin
                if (load) begin
                    if (pop) begin
                        n_state = i_cmd.refill ? ST_RF2 : ST_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
            r_row <= i_row;
            r_col <= i_col;
        end
    end

    // line store port control: reads walk up to the column, writes go to the older bank
    always_comb begin
        rd_en   = (r_state == ST_RF2) || (r_state == ST_RF1) || (r_state == ST_RD);
        rd_addr = r_col;
        if (r_state == ST_RF2) begin
            rd_addr = r_col - COL_W'(2);
        end else if (r_state == ST_RF1) begin
            rd_addr = r_col - COL_W'(1);
        end
        wr_en   = 1'b0;
        wr_addr = r_col;
        wr_data = r_cmd.pix;
        if (r_state == ST_RD) begin
            wr_en   = (r_col != '0);
            wr_addr = r_col - COL_W'(1);
            wr_data = r_cmd.prev1;
        end else if (load) begin
            wr_en   = r_cmd.endc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_cmd.nsel) begin
            r_bank0[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd0 <= r_bank0[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_cmd.nsel) begin
            r_bank1[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd1 <= r_bank1[rd_addr];
        end
    end

    assign n0 = r_cmd.nsel ? r_rd1 : r_rd0;
    assign o0 = r_cmd.nsel ? r_rd0 : r_rd1;

    // window of the two columns left of the last read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_n1 <= n0;
            r_n2 <= r_n1;
            r_o1 <= o0;
        end
    end

    assign r_ge1 = (r_row != '0);
    assign r_ge2 = (r_row > ROW_W'(1));
    assign c_ge1 = (r_col != '0);
    assign c_ge2 = (r_col > COL_W'(1));

    assign row_up   = pos9(32'(r_row - ROW_W'(1)));
    assign row_at   = pos9(32'(r_row));
    assign col_left = pos9(32'(r_col - COL_W'(1)));
    assign col_at   = pos9(32'(r_col));

    always_comb begin
        blk_v[0]   = c_ge1 && r_ge1;
        blk[0].row = row_up;
        blk[0].col = col_left;
        blk[0].pix = scale2x(r_n1, r_ge2 ? r_o1 : r_n1, r_cmd.prev1,
                             c_ge2 ? r_n2 : r_n1, n0);

        blk_v[1]   = c_ge1 && r_cmd.lastrow;
        blk[1].row = row_at;
        blk[1].col = col_left;
        blk[1].pix = scale2x(r_cmd.prev1, r_ge1 ? r_n1 : r_cmd.prev1, r_cmd.prev1,
                             c_ge2 ? r_cmd.prev2 : r_cmd.prev1, r_cmd.pix);

        blk_v[2]   = r_cmd.endc && r_ge1;
        blk[2].row = row_up;
        blk[2].col = col_at;
        blk[2].pix = scale2x(n0, r_ge2 ? o0 : n0, r_cmd.pix, c_ge1 ? r_n1 : n0, n0);

        blk_v[3]   = r_cmd.endc && r_cmd.lastrow;
        blk[3].row = row_at;
        blk[3].col = col_at;
        blk[3].pix = scale2x(r_cmd.pix, r_ge1 ? n0 : r_cmd.pix, r_cmd.pix,
                             c_ge1 ? r_cmd.prev1 : r_cmd.pix, r_cmd.pix);
    end

    // pack the present blocks to the front of the buffer in order
    always_comb begin
        n_cnt  = '0;
        n_slot = '{default: '0};
        for (int k = 0; k < NUM_BLK; k++) begin
            if (blk_v[k]) begin
                n_slot[n_cnt[1:0]] = blk[k];
                n_cnt              = n_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else if (load) begin
            r_idx <= '0;
            r_cnt <= n_cnt;
        end else if (o_out_valid && i_out_ready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    assign o_out_valid    = (r_idx != r_cnt);
    assign o_out_row      = r_slot[r_idx[1:0]].row;
    assign o_out_col      = r_slot[r_idx[1:0]].col;
    assign o_top_left     = r_slot[r_idx[1:0]].pix.tl;
    assign o_top_right    = r_slot[r_idx[1:0]].pix.tr;
    assign o_bottom_left  = r_slot[r_idx[1:0]].pix.bl;
    assign o_bottom_right = r_slot[r_idx[1:0]].pix.br;
    assign o_last         = (r_idx + 3'd1 == r_cnt);

endmodule

// ===== sv/scale2x_pixel_upscaler.sv =====
// scale2x upscaler top level: front, command queue and back
// an accepted word passes through the command queue, then the back reads the line stores and loads the result buffer
// per pixel the back runs a line store read state, then a write/compute state that waits for the result buffer
// a pixel after a mid-row width cut first passes the refill reads RF2 and RF1 to reload the neighbour window
// results leave one per cycle while the receiver is ready; up to 4 per pixel at the end of the last row
// reset clears counters, bank select and queues; line stores are not cleared
module scale2x_pixel_upscaler import s2x_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POS_W-1:0]     o_out_row,
    output logic [POS_W-1:0]     o_out_col,
    output logic [PIX_W-1:0]     o_top_left,
    output logic [PIX_W-1:0]     o_top_right,
    output logic [PIX_W-1:0]     o_bottom_left,
    output logic [PIX_W-1:0]     o_bottom_right,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int Q_W   = $bits(t_cmd) + ROW_W + COL_W;

    t_cmd             f_cmd, b_cmd;
    logic [ROW_W-1:0] f_row, b_row;
    logic [COL_W-1:0] f_col, b_col;
    logic             push, pop, q_full, q_valid;
    logic [Q_W-1:0]   q_out;

    s2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .o_row      (f_row),
        .o_col      (f_col)
    );

    s2x_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_row, f_col}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_cmd, b_row, b_col} = q_out;

    s2x_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (pop),
        .i_cmd          (b_cmd),
        .i_row          (b_row),
        .i_col          (b_col),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_last         (o_last)
    );

endmodule

// ===== tb/tb_scale2x_pixel_upscaler.sv =====
// self-checking bench for scale2x_pixel_upscaler: stream driver, result monitor
// and a scale2x predictor with its own line stores; needs s2x_pkg and the rtl
`timescale 1ns / 100ps

module tb_scale2x_pixel_upscaler;
    import s2x_pkg::*;

    localparam int FRAME_MAX    = 512;
    localparam int QUIET_CYCLES = 20;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 150;
    localparam int WIDE_ITEMS   = 160;
    localparam int TALL_ITEMS   = 48;
    localparam int RANDOM_ITEMS = 220;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
        logic             last;
    } t_scaled_block;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [POS_W-1:0]     o_out_row;
    logic [POS_W-1:0]     o_out_col;
    logic [PIX_W-1:0]     o_top_left;
    logic [PIX_W-1:0]     o_top_right;
    logic [PIX_W-1:0]     o_bottom_left;
    logic [PIX_W-1:0]     o_bottom_right;
    logic                 o_last;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    scale2x_pixel_upscaler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // predictor state
    logic [PIX_W-1:0] line_mem [2][FRAME_MAX];
    logic             bank_sel = 1'b0;
    int unsigned      next_row = 0;
    int unsigned      next_col = 0;
    logic [PIX_W-1:0] last_pix = '0;
    logic [PIX_W-1:0] prior_pix = '0;
    int unsigned      cfg_width = FRAME_WIDTH_RST;
    int unsigned      cfg_height = FRAME_HEIGHT_RST;

    logic [PIX_W-1:0] src_pixels [$];
    t_scaled_block    scaled_blocks [$];

    bit pix_taken = 1'b0;
    bit blk_taken = 1'b0;
    bit hold_req = 1'b0;
    int mismatches = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        foreach (line_mem[b, a]) line_mem[b][a] = '0;
    end

    function automatic int unsigned clamp_size(input int unsigned v);
        if (v == 0) return 1;
        if (v > FRAME_MAX) return FRAME_MAX;
        return v;
    endfunction

    function automatic t_scaled_block scale_block(input int unsigned r, input int unsigned c,
            input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] h,
            input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] f);
        t_scaled_block k;
        k.row  = POS_W'(r);
        k.col  = POS_W'(c);
        k.last = 1'b0;
        if (b != h && d != f) begin
            k.tl = (d == b) ? d : e;
            k.tr = (b == f) ? f : e;
            k.bl = (d == h) ? d : e;
            k.br = (h == f) ? f : e;
        end else begin
            k.tl = e;
            k.tr = e;
            k.bl = e;
            k.br = e;
        end
        return k;
    endfunction

    // expand one accepted source pixel into the blocks it releases
    function automatic void scale_pixel(input logic [PIX_W-1:0] p);
        int unsigned   w, hgt, r, c, x;
        logic          nb, ob, endc, lastrow;
        t_scaled_block found [4];
        int            n;
        w   = clamp_size(cfg_width);
        hgt = clamp_size(cfg_height);
        r   = next_row;
        c   = next_col;
        n   = 0;
        if (c > w - 1) c = w - 1;
        if (r > hgt - 1) r = hgt - 1;
        endc    = (c == w - 1);
        lastrow = (r == hgt - 1);
        nb = bank_sel;
        ob = ~bank_sel;
        if (c >= 1) begin
            x = c - 1;
            if (r >= 1) begin
                found[n] = scale_block(r - 1, x, line_mem[nb][x],
                    (r >= 2) ? line_mem[ob][x] : line_mem[nb][x], last_pix,
                    (x >= 1) ? line_mem[nb][x-1] : line_mem[nb][x], line_mem[nb][c]);
                n++;
            end
            if (lastrow) begin
                found[n] = scale_block(r, x, last_pix,
                    (r >= 1) ? line_mem[nb][x] : last_pix, last_pix,
                    (x >= 1) ? prior_pix : last_pix, p);
                n++;
            end
        end
        if (endc) begin
            if (r >= 1) begin
                found[n] = scale_block(r - 1, c, line_mem[nb][c],
                    (r >= 2) ? line_mem[ob][c] : line_mem[nb][c], p,
                    (c >= 1) ? line_mem[nb][c-1] : line_mem[nb][c], line_mem[nb][c]);
                n++;
            end
            if (lastrow) begin
                found[n] = scale_block(r, c, p, (r >= 1) ? line_mem[nb][c] : p, p,
                    (c >= 1) ? last_pix : p, p);
                n++;
            end
        end
        // current row goes into the older bank one column behind the reads
        if (c >= 1) line_mem[ob][c-1] = last_pix;
        if (endc) line_mem[ob][c] = p;
        prior_pix = last_pix;
        last_pix  = p;
        if (endc) begin
            next_col = 0;
            bank_sel = ~bank_sel;
            next_row = lastrow ? 0 : r + 1;
        end else begin
            next_col = c + 1;
            next_row = r;
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) found[i].last = 1'b1;
            scaled_blocks = {scaled_blocks, found[i]};
        end
    endfunction

    function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
            input logic [PIX_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // acceptance, prediction and result checking, all on the rising edge
    always @(posedge i_clk) begin
        t_scaled_block want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            scale_pixel(i_pixel);
            pix_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            blk_taken = 1'b1;
            if (scaled_blocks.size() == 0) begin
                $error("unexpected block at row %0d col %0d", o_out_row, o_out_col);
                mismatches++;
            end else begin
                want = scaled_blocks.pop_front();
                check_field("out_row", PIX_W'(want.row), PIX_W'(o_out_row));
                check_field("out_col", PIX_W'(want.col), PIX_W'(o_out_col));
                check_field("top_left", want.tl, o_top_left);
                check_field("top_right", want.tr, o_top_right);
                check_field("bottom_left", want.bl, o_bottom_left);
                check_field("bottom_right", want.br, o_bottom_right);
                check_field("last", PIX_W'(want.last), PIX_W'(o_last));
            end
        end
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // pixel driver
    int send_gap = 0;
    bit send_calm = 1'b0;
    always @(negedge i_clk) begin
        logic nxt_valid;
        if (i_rst_n !== 1'b1) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (pix_taken) begin
                nxt_valid = 1'b0;
                pix_taken = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (src_pixels.size() > 0) begin
                    i_pixel <= src_pixels.pop_front();
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 24) == 0) send_calm = ~send_calm;
                    send_gap = draw_wait(send_calm);
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // result receiver
    int recv_gap = 0;
    int hold_left = 0;
    bit recv_calm = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_out_ready <= 1'b0;
        end else begin
            if (blk_taken) begin
                blk_taken = 1'b0;
                if ($urandom_range(0, 24) == 0) recv_calm = ~recv_calm;
                recv_gap = draw_wait(recv_calm);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("scale2x_pixel_upscaler regression: fail");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        if (idx == REG_FRAME_WIDTH) cfg_width = val & 10'h3FF;
        else cfg_height = val & 10'h3FF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block is idle once every word is in, every block is out and the pipe has emptied
    task automatic wait_quiet();
        while (src_pixels.size() != 0 || i_in_valid || scaled_blocks.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // pixels mostly from a small palette so that neighbour matches happen often
    task automatic queue_pixels(input int n);
        logic [PIX_W-1:0] pal [3];
        foreach (pal[k]) begin
            case ($urandom_range(0, 5))
                0:       pal[k] = '0;
                1:       pal[k] = '1;
                default: pal[k] = $urandom;
            endcase
        end
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) src_pixels = {src_pixels, pal[$urandom_range(0, 2)]};
            else src_pixels = {src_pixels, PIX_W'($urandom)};
        end
    endtask

    initial begin
        int unsigned nw, nh, fw, fh;
        int          n, rand_sent;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero sizes behave as a 1x1 frame
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        src_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A};
        wait_quiet();

        // 3x3 frame whose centre takes the diagonal corners
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        src_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
                       32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                       32'hA5A5_A5A5, 32'h0000_0001, 32'h0000_0000};
        wait_quiet();

        // oversized height, then cut below the current row mid frame
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 1000);
        queue_pixels(4);
        wait_quiet();
        write_reg(REG_FRAME_HEIGHT, 2);
        queue_pixels(2);
        wait_quiet();

        // width cut mid row while the column is already past the new end
        write_reg(REG_FRAME_WIDTH, 5);
        queue_pixels(3);
        wait_quiet();
        write_reg(REG_FRAME_WIDTH, 2);
        queue_pixels(3);
        wait_quiet();

        // widest row with a long output stall so the input backs up
        write_reg(REG_FRAME_WIDTH, 1023);
        write_reg(REG_FRAME_HEIGHT, 1);
        hold_req = 1'b1;
        queue_pixels(WIDE_ITEMS);
        wait_quiet();

        // tallest frame, one column, first rows
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, FRAME_MAX);
        queue_pixels(TALL_ITEMS);
        wait_quiet();

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       nw = 0;
                    1:       nw = $urandom_range(FRAME_MAX + 1, 1023);
                    2:       nw = FRAME_MAX;
                    default: nw = $urandom_range(1, 8);
                endcase
                // widening past rows already stored would read unwritten entries
                if (next_row == 0 || clamp_size(nw) <= clamp_size(cfg_width))
                    write_reg(REG_FRAME_WIDTH, nw);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       nh = 0;
                    1:       nh = $urandom_range(FRAME_MAX + 1, 1023);
                    2:       nh = FRAME_MAX;
                    default: nh = $urandom_range(1, 6);
                endcase
                write_reg(REG_FRAME_HEIGHT, nh);
            end
            fw = clamp_size(cfg_width);
            fh = clamp_size(cfg_height);
            if (fw * fh <= 48 && $urandom_range(0, 3) != 0) n = fw * fh;
            else n = $urandom_range(1, 24);
            queue_pixels(n);
            rand_sent += n;
            wait_quiet();
        end

        if (mismatches == 0)
            $display("scale2x_pixel_upscaler regression: pass");
        else
            $display("scale2x_pixel_upscaler regression: fail");
        $finish;
    end

endmodule
